@@ rtl/bsm_pkg.sv @@
package bsm_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int RAD_WIDTH   = COORD_WIDTH - 1;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int SQR_WIDTH   = 2 * DIFF_WIDTH;
   localparam int LSQ_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int TRIAL_WIDTH = LSQ_WIDTH + 1;
   localparam int ROOT_WIDTH  = COORD_WIDTH + 1;
   localparam int NUM_WIDTH   = ROOT_WIDTH + 1;
   localparam int SUM_WIDTH   = ROOT_WIDTH + 2;
   localparam int DVSR_WIDTH  = ROOT_WIDTH + 1;
   localparam int QUO_WIDTH   = DIFF_WIDTH;
   localparam int DVD_WIDTH   = QUO_WIDTH + DVSR_WIDTH;

   // pipeline stage map
   localparam int SQ_FIRST    = 3;
   localparam int SQ_STAGES   = ROOT_WIDTH;
   localparam int PREP_STAGE  = SQ_FIRST + SQ_STAGES;
   localparam int MUL_STAGE   = PREP_STAGE + 1;
   localparam int DVD_STAGE   = MUL_STAGE + 1;
   localparam int DIV_FIRST   = DVD_STAGE + 1;
   localparam int DIV_STAGES  = QUO_WIDTH;
   localparam int LAST_STAGE  = DIV_FIRST + DIV_STAGES - 1;
   localparam int STAGES      = LAST_STAGE + 1;

   typedef struct packed {
      logic                             p0;
      logic                             p1;
      logic [2:0][COORD_WIDTH-1:0]      c0;
      logic [2:0][COORD_WIDTH-1:0]      c1;
      logic [RAD_WIDTH-1:0]             r0;
      logic [RAD_WIDTH-1:0]             r1;
      logic [2:0]                       neg;
      logic [2:0][DIFF_WIDTH-1:0]       ad;
      logic                             rd_neg;
      logic                             contain;
      logic [ROOT_WIDTH-1:0]            len;
      logic [SUM_WIDTH-1:0]             sum;
   } item_type;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0]      center;
      logic [RAD_WIDTH-1:0]             radius;
      logic                             clipped;
   } result_type;

endpackage

@@ rtl/bounding_sphere_merge_unit.sv @@
// Smallest sphere enclosing two spheres, Q15.16 centers and radii.
// Request channel (req_*): one word carries both spheres and their present
// flags; it is taken at a clock edge where req_valid is high and req_stall
// is low. Response channel (rsp_*): one word per request, in request order,
// taken where rsp_valid is high and rsp_stall is low.
// One request is accepted every cycle while req_stall is low: the datapath
// is a 72-stage pipeline (difference and squares, a 33-stage integer square
// root, center-offset product, then three 33-stage restoring dividers
// running side by side, one quotient bit per stage).
// Results drain into a two-word output queue. While the queue is full the
// whole pipeline holds and req_stall is high; nothing is dropped or
// repeated, and a word on rsp_* stays put while rsp_stall is high.
// Synchronous reset empties the pipeline and the queue; no word is valid
// on either channel's handshake side after reset until new requests arrive.
module bounding_sphere_merge_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_first_present,
   input  logic signed [bsm_pkg::COORD_WIDTH-1:0] req_first_x,
   input  logic signed [bsm_pkg::COORD_WIDTH-1:0] req_first_y,
   input  logic signed [bsm_pkg::COORD_WIDTH-1:0] req_first_z,
   input  logic [bsm_pkg::RAD_WIDTH-1:0]       req_first_radius,
   input  logic                                req_second_present,
   input  logic signed [bsm_pkg::COORD_WIDTH-1:0] req_second_x,
   input  logic signed [bsm_pkg::COORD_WIDTH-1:0] req_second_y,
   input  logic signed [bsm_pkg::COORD_WIDTH-1:0] req_second_z,
   input  logic [bsm_pkg::RAD_WIDTH-1:0]       req_second_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [bsm_pkg::COORD_WIDTH-1:0] rsp_merged_x,
   output logic signed [bsm_pkg::COORD_WIDTH-1:0] rsp_merged_y,
   output logic signed [bsm_pkg::COORD_WIDTH-1:0] rsp_merged_z,
   output logic [bsm_pkg::RAD_WIDTH-1:0]       rsp_merged_radius,
   output logic                                rsp_radius_clipped
);

   localparam int CW = bsm_pkg::COORD_WIDTH;
   localparam int RW = bsm_pkg::RAD_WIDTH;
   localparam int NS = bsm_pkg::STAGES;
   localparam int LAST = bsm_pkg::LAST_STAGE;

   logic                 go;
   logic                 valid_ff [NS];
   bsm_pkg::item_type    item_ff  [NS];
   bsm_pkg::item_type    item_in  [NS];
   bsm_pkg::item_type    entry;

   logic [RW-1:0]                        ard_ff;
   logic [RW-1:0]                        ard_in;
   logic [bsm_pkg::SQR_WIDTH-1:0]        sq_ff [3];
   logic [bsm_pkg::LSQ_WIDTH-1:0]        ardsq_ff;
   logic [bsm_pkg::LSQ_WIDTH-1:0]        lsq_ff;
   logic [bsm_pkg::LSQ_WIDTH-1:0]        lsq_in;
   logic [bsm_pkg::LSQ_WIDTH-1:0]        sq_rem_ff  [bsm_pkg::SQ_STAGES];
   logic [bsm_pkg::ROOT_WIDTH-1:0]       sq_root_ff [bsm_pkg::SQ_STAGES];
   logic [bsm_pkg::ROOT_WIDTH-1:0]       root;
   logic [bsm_pkg::NUM_WIDTH-1:0]        num_ff;
   logic [bsm_pkg::DVD_WIDTH-1:0]        prod_ff [3];
   logic [bsm_pkg::DVD_WIDTH-1:0]        dvd_ff  [3];
   logic [bsm_pkg::QUO_WIDTH-1:0]        quo     [3];

   bsm_pkg::result_type  result;
   bsm_pkg::result_type  queue_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 push;
   logic                 pop;

   // hold the whole pipeline while the output queue is full
   assign go        = (count_ff != 2'd2);
   assign req_stall = !go;

   // stage 0: center differences and radius difference
   always_comb begin
      logic [bsm_pkg::DIFF_WIDTH-1:0] diff;
      logic [CW-1:0]                  rd;
      logic [CW-1:0]                  rd_abs;
      entry         = '0;
      entry.p0      = req_first_present;
      entry.p1      = req_second_present;
      entry.c0[0]   = req_first_x;
      entry.c0[1]   = req_first_y;
      entry.c0[2]   = req_first_z;
      entry.c1[0]   = req_second_x;
      entry.c1[1]   = req_second_y;
      entry.c1[2]   = req_second_z;
      entry.r0      = req_first_radius;
      entry.r1      = req_second_radius;
      for (int i = 0; i < 3; i++) begin
         diff = {entry.c1[i][CW-1], entry.c1[i]} - {entry.c0[i][CW-1], entry.c0[i]};
         entry.neg[i] = diff[bsm_pkg::DIFF_WIDTH-1];
         entry.ad[i]  = entry.neg[i] ? -diff : diff;
      end
      rd           = {1'b0, req_second_radius} - {1'b0, req_first_radius};
      entry.rd_neg = rd[CW-1];
      rd_abs       = -rd;
      ard_in       = entry.rd_neg ? rd_abs[RW-1:0] : rd[RW-1:0];
   end

   assign lsq_in = bsm_pkg::LSQ_WIDTH'(sq_ff[0]) + bsm_pkg::LSQ_WIDTH'(sq_ff[1])
                 + bsm_pkg::LSQ_WIDTH'(sq_ff[2]);
   assign root   = sq_root_ff[bsm_pkg::SQ_STAGES-1];

   // side data rides along; a few stages fill in their fields
   always_comb begin
      item_in[0] = entry;
      for (int s = 1; s < NS; s++) begin
         item_in[s] = item_ff[s-1];
      end
      item_in[2].contain = (lsq_in <= ardsq_ff);
      item_in[bsm_pkg::PREP_STAGE].len = root;
      item_in[bsm_pkg::PREP_STAGE].sum = bsm_pkg::SUM_WIDTH'(root)
         + bsm_pkg::SUM_WIDTH'(item_ff[bsm_pkg::PREP_STAGE-1].r1)
         + bsm_pkg::SUM_WIDTH'(item_ff[bsm_pkg::PREP_STAGE-1].r0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (go) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s < NS; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         for (int s = 0; s < NS; s++) begin
            item_ff[s] <= item_in[s];
         end
         ard_ff   <= ard_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= bsm_pkg::SQR_WIDTH'(item_ff[0].ad[i])
                      * bsm_pkg::SQR_WIDTH'(item_ff[0].ad[i]);
         end
         ardsq_ff <= bsm_pkg::LSQ_WIDTH'(ard_ff) * bsm_pkg::LSQ_WIDTH'(ard_ff);
         lsq_ff   <= lsq_in;
         num_ff   <= bsm_pkg::NUM_WIDTH'(root)
                   + bsm_pkg::NUM_WIDTH'(item_ff[bsm_pkg::PREP_STAGE-1].r1)
                   - bsm_pkg::NUM_WIDTH'(item_ff[bsm_pkg::PREP_STAGE-1].r0);
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= bsm_pkg::DVD_WIDTH'(item_ff[bsm_pkg::PREP_STAGE].ad[i])
                        * bsm_pkg::DVD_WIDTH'(num_ff);
            dvd_ff[i]  <= prod_ff[i] + bsm_pkg::DVD_WIDTH'(item_ff[bsm_pkg::MUL_STAGE].len);
         end
      end
   end

   // floor square root, one result bit per stage; remainder holds v - root^2
   for (genvar k = 0; k < bsm_pkg::SQ_STAGES; k++) begin : g_root
      localparam int B = bsm_pkg::ROOT_WIDTH - 1 - k;
      logic [bsm_pkg::LSQ_WIDTH-1:0]   rem_prev;
      logic [bsm_pkg::ROOT_WIDTH-1:0]  root_prev;
      logic [bsm_pkg::TRIAL_WIDTH-1:0] trial;
      logic [bsm_pkg::LSQ_WIDTH-1:0]   rem_in;
      logic [bsm_pkg::ROOT_WIDTH-1:0]  root_in;

      if (k == 0) begin : g_head
         assign rem_prev  = lsq_ff;
         assign root_prev = '0;
      end else begin : g_body
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
      end

      assign trial = (bsm_pkg::TRIAL_WIDTH'(root_prev) << (B + 1))
                   | (bsm_pkg::TRIAL_WIDTH'(1) << (2 * B));

      always_comb begin
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = bsm_pkg::LSQ_WIDTH'({1'b0, rem_prev} - trial);
            root_in = root_prev | (bsm_pkg::ROOT_WIDTH'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (go) begin
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      bsm_divider u_divider (
         .clock    (clock),
         .advance  (go),
         .dividend (dvd_ff[i]),
         .divisor  ({item_ff[bsm_pkg::DVD_STAGE].len, 1'b0}),
         .quotient (quo[i])
      );
   end

   // case selection and radius saturation on the last stage
   always_comb begin
      logic [bsm_pkg::SUM_WIDTH-2:0] half;
      logic [CW-1:0]                 off;
      bsm_pkg::item_type             it;
      it     = item_ff[LAST];
      half   = it.sum[bsm_pkg::SUM_WIDTH-1:1];
      off    = '0;
      result = '0;
      if (it.p0 && it.p1) begin
         if (it.contain) begin
            result.center = it.rd_neg ? it.c0 : it.c1;
            result.radius = it.rd_neg ? it.r0 : it.r1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               off = it.neg[i] ? -quo[i][CW-1:0] : quo[i][CW-1:0];
               result.center[i] = it.c0[i] + off;
            end
            if (half[bsm_pkg::SUM_WIDTH-2:RW] != '0) begin
               result.radius  = '1;
               result.clipped = 1'b1;
            end else begin
               result.radius  = half[RW-1:0];
            end
         end
      end else if (it.p0) begin
         result.center = it.c0;
         result.radius = it.r0;
      end else if (it.p1) begin
         result.center = it.c1;
         result.radius = it.r1;
      end
   end

   assign push = go && valid_ff[LAST];
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_valid          = (count_ff != 2'd0);
   assign rsp_merged_x       = queue_ff[rd_ptr_ff].center[0];
   assign rsp_merged_y       = queue_ff[rd_ptr_ff].center[1];
   assign rsp_merged_z       = queue_ff[rd_ptr_ff].center[2];
   assign rsp_merged_radius  = queue_ff[rd_ptr_ff].radius;
   assign rsp_radius_clipped = queue_ff[rd_ptr_ff].clipped;

endmodule

@@ rtl/bsm_divider.sv @@
module bsm_divider (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [bsm_pkg::DVD_WIDTH-1:0]     dividend,
   input  logic [bsm_pkg::DVSR_WIDTH-1:0]    divisor,
   output logic [bsm_pkg::QUO_WIDTH-1:0]     quotient
);

   localparam int QW = bsm_pkg::QUO_WIDTH;
   localparam int VW = bsm_pkg::DVSR_WIDTH;
   localparam int DW = bsm_pkg::DVD_WIDTH;

   logic [VW-1:0] rem_ff  [QW];
   logic [VW-1:0] dvsr_ff [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int J = QW - 1 - k;
      logic [VW-1:0] rem_prev;
      logic [VW-1:0] dvsr_prev;
      logic [QW-1:0] low_prev;
      logic [QW-1:0] quo_prev;
      logic [VW:0]   trial;
      logic [VW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_head
         assign rem_prev  = dividend[DW-1:QW];
         assign dvsr_prev = divisor;
         assign low_prev  = dividend[QW-1:0];
         assign quo_prev  = '0;
      end else begin : g_body
         assign rem_prev  = rem_ff[k-1];
         assign dvsr_prev = dvsr_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
      end

      assign trial = {rem_prev, low_prev[J]};

      always_comb begin
         if (trial >= {1'b0, dvsr_prev}) begin
            rem_in = VW'(trial - {1'b0, dvsr_prev});
            quo_in = quo_prev | (QW'(1) << J);
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            dvsr_ff[k] <= dvsr_prev;
            low_ff[k]  <= low_prev;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

@@ sim/sphere_merge_checker.sv @@
module sphere_merge_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_first_present,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        req_first_x,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        req_first_y,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        req_first_z,
   input  logic [bsm_pkg::RAD_WIDTH-1:0]          req_first_radius,
   input  logic                                   req_second_present,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        req_second_x,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        req_second_y,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        req_second_z,
   input  logic [bsm_pkg::RAD_WIDTH-1:0]          req_second_radius,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        rsp_merged_x,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        rsp_merged_y,
   input  logic [bsm_pkg::COORD_WIDTH-1:0]        rsp_merged_z,
   input  logic [bsm_pkg::RAD_WIDTH-1:0]          rsp_merged_radius,
   input  logic                                   rsp_radius_clipped,
   output int                                     failures,
   output int                                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [bsm_pkg::COORD_WIDTH-1:0] coord_type;
   typedef logic [bsm_pkg::RAD_WIDTH-1:0]   radius_type;

   typedef struct packed {
      coord_type  x;
      coord_type  y;
      coord_type  z;
      radius_type radius;
      logic       clipped;
   } merged_sphere_type;

   merged_sphere_type expected_spheres[$];

   localparam logic [127:0] RAD_MAX = (128'd1 << bsm_pkg::RAD_WIDTH) - 1;

   function automatic merged_sphere_type merge_spheres(
      input logic p0, input coord_type c0[3], input radius_type r0,
      input logic p1, input coord_type c1[3], input radius_type r1);
      merged_sphere_type m;
      longint         d[3];
      logic [127:0]   ad[3];
      longint         rd;
      logic [127:0]   ard;
      logic [127:0]   lsq;
      logic [127:0]   root;
      logic [127:0]   cand;
      logic [127:0]   num;
      logic [127:0]   q;
      logic [127:0]   rad;
      coord_type      res[3];
      m = '0;
      if (p0 && p1) begin
         rd  = longint'(r1) - longint'(r0);
         ard = (rd < 0) ? 128'(-rd) : 128'(rd);
         lsq = '0;
         for (int i = 0; i < 3; i++) begin
            d[i]  = longint'($signed(c1[i])) - longint'($signed(c0[i]));
            ad[i] = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
            lsq   = lsq + ad[i] * ad[i];
         end
         if (lsq <= ard * ard) begin
            // one sphere swallows the other; ties go to the second
            for (int i = 0; i < 3; i++) res[i] = (rd >= 0) ? c1[i] : c0[i];
            m.radius = (rd >= 0) ? r1 : r0;
         end else begin
            root = '0;
            for (int b = 40; b >= 0; b--) begin
               cand = root | (128'd1 << b);
               if (cand * cand <= lsq) root = cand;
            end
            num = root + 128'(r1) - 128'(r0);
            for (int i = 0; i < 3; i++) begin
               // round half away from zero, then restore the sign
               q = (ad[i] * num + root) / (2 * root);
               res[i] = (d[i] < 0) ? c0[i] - coord_type'(q) : c0[i] + coord_type'(q);
            end
            rad = (root + 128'(r1) + 128'(r0)) >> 1;
            if (rad > RAD_MAX) begin
               m.radius  = radius_type'(RAD_MAX);
               m.clipped = 1'b1;
            end else begin
               m.radius = radius_type'(rad);
            end
         end
         m.x = res[0];
         m.y = res[1];
         m.z = res[2];
      end else if (p0) begin
         m.x = c0[0]; m.y = c0[1]; m.z = c0[2]; m.radius = r0;
      end else if (p1) begin
         m.x = c1[0]; m.y = c1[1]; m.z = c1[2]; m.radius = r1;
      end
      return m;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      failures++;
   endtask

   initial failures = 0;
   initial pending = 0;

   always @(posedge clock) begin
      coord_type         c0[3];
      coord_type         c1[3];
      merged_sphere_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            c0 = '{req_first_x, req_first_y, req_first_z};
            c1 = '{req_second_x, req_second_y, req_second_z};
            expected_spheres.push_back(merge_spheres(req_first_present, c0,
               req_first_radius, req_second_present, c1, req_second_radius));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_spheres.size() == 0) begin
               $display("%0t: unexpected result word", $realtime);
               failures++;
            end else begin
               want = expected_spheres.pop_front();
               if (rsp_merged_x !== want.x)
                  report_mismatch("x", 64'(rsp_merged_x), 64'(want.x));
               if (rsp_merged_y !== want.y)
                  report_mismatch("y", 64'(rsp_merged_y), 64'(want.y));
               if (rsp_merged_z !== want.z)
                  report_mismatch("z", 64'(rsp_merged_z), 64'(want.z));
               if (rsp_merged_radius !== want.radius)
                  report_mismatch("radius", 64'(rsp_merged_radius), 64'(want.radius));
               if (rsp_radius_clipped !== want.clipped)
                  report_mismatch("clipped", 64'(rsp_radius_clipped), 64'(want.clipped));
            end
         end
      end
      pending <= expected_spheres.size();
   end

endmodule

@@ sim/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1200;
   localparam int IDLE_LIMIT   = 5000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_first_present = 1'b0;
   logic [bsm_pkg::COORD_WIDTH-1:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic [bsm_pkg::RAD_WIDTH-1:0]   req_first_radius = '0;
   logic                            req_second_present = 1'b0;
   logic [bsm_pkg::COORD_WIDTH-1:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic [bsm_pkg::RAD_WIDTH-1:0]   req_second_radius = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [bsm_pkg::COORD_WIDTH-1:0] rsp_merged_x, rsp_merged_y, rsp_merged_z;
   logic [bsm_pkg::RAD_WIDTH-1:0]   rsp_merged_radius;
   logic                            rsp_radius_clipped;
   int                              failures;
   int                              pending;
   bit                              sender_idles = 1'b1;
   bit                              receiver_idles = 1'b1;
   int                              stall_left = 0;
   int                              idle_cycles = 0;

   always #6 clock = ~clock;

   bounding_sphere_merge_unit DUT (.*);

   sphere_merge_checker checker_i (.*);

   // receiver back-pressure: after each taken word, while receiver_idles is set, optionally hold stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_valid && !rsp_stall && receiver_idles) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall  <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_pair(input logic p0, input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] z0, input logic [30:0] r0, input logic p1,
                            input logic [31:0] x1, input logic [31:0] y1,
                            input logic [31:0] z1, input logic [30:0] r1);
      int gap;
      req_valid          <= 1'b1;
      req_first_present  <= p0;
      req_first_x        <= x0;
      req_first_y        <= y0;
      req_first_z        <= z0;
      req_first_radius   <= r0;
      req_second_present <= p1;
      req_second_x       <= x1;
      req_second_y       <= y1;
      req_second_z       <= z1;
      req_second_radius  <= r1;
      do @(posedge clock); while (req_stall);
      gap = sender_idles ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_random_pair();
      int          shift;
      logic [31:0] base[3];
      logic [31:0] c[6];
      logic [30:0] r[2];
      logic        p0, p1;
      shift = $urandom_range(0, 31);
      for (int i = 0; i < 3; i++) base[i] = $urandom;
      for (int i = 0; i < 6; i++) begin
         // near centers most of the time so merges are genuine
         if ($urandom_range(0, 3) == 0) c[i] = $urandom;
         else c[i] = base[i % 3] + ($signed($urandom) >>> shift);
      end
      for (int i = 0; i < 2; i++) begin
         if ($urandom_range(0, 5) == 0) r[i] = 31'($urandom);
         else r[i] = 31'($urandom >> (shift + 1));
      end
      p0 = ($urandom_range(0, 9) != 0) ? 1'b1 : 1'($urandom);
      p1 = ($urandom_range(0, 9) != 0) ? 1'b1 : 1'($urandom);
      send_pair(p0, c[0], c[1], c[2], r[0], p1, c[3], c[4], c[5], r[1]);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(1'b0, 32'h1, 32'h2, 32'h3, 31'h5, 1'b0, 32'h7, 32'h8, 32'h9, 31'ha);
      send_pair(1'b1, 32'h10000, 32'hffff0000, 32'h0, 31'h20000,
                1'b0, 32'h1, 32'h1, 32'h1, 31'h1);
      send_pair(1'b0, 32'h1, 32'h1, 32'h1, 31'h1, 1'b1, 32'h80000000, 32'h7fffffff, 32'h0,
                31'h7fffffff);
      send_pair(1'b1, 32'h0, 32'h0, 32'h0, 31'h50000, 1'b1, 32'h10000, 32'h0, 32'h0,
                31'h10000);
      send_pair(1'b1, 32'h0, 32'h0, 32'h0, 31'h10000, 1'b1, 32'h10000, 32'h0, 32'h0,
                31'h50000);
      send_pair(1'b1, 32'h1234, 32'h5678, 32'h9abc, 31'h777, 1'b1, 32'h1234, 32'h5678,
                32'h9abc, 31'h777);
      send_pair(1'b1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1, 32'h0, 32'h0, 32'h0, 31'h0);
      send_pair(1'b1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1, 32'h10000, 32'h0, 32'h0, 31'h0);
      send_pair(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
      send_pair(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h0,
                1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000, 31'h0);
      // floor root lands exactly on the radius difference
      send_pair(1'b1, 32'h0, 32'h0, 32'h0, 31'h0, 1'b1, 32'h1, 32'h5, 32'h0, 31'h5);
      send_pair(1'b1, 32'h0, 32'h0, 32'h0, 31'h5, 1'b1, 32'hffffffff, 32'hfffffffb, 32'h0,
                31'h0);
      send_pair(1'b1, 32'hfffe0000, 32'h30000, 32'hffff8000, 31'h8000,
                1'b1, 32'h20000, 32'hfffd0000, 32'h8000, 31'h18000);
      send_pair(1'b1, 32'h3, 32'h0, 32'h0, 31'h1, 1'b1, 32'h0, 32'h4, 32'h0, 31'h2);

      // hold off until the pipeline is empty
      drain_results();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 200 == 0) begin
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
         end
         send_random_pair();
      end

      drain_results();
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
